// ----- sv/mcdbe_pkg.sv -----
// Package for the multi-column delta byte encoder.
// Holds sizes, register indexes, code kinds and byte masks.
// Depends on nothing; used by multi_column_delta_byte_encoder_core.
package mcdbe_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

  typedef logic [COL_W-1:0] col_idx_t;
  typedef logic [CNT_W-1:0] col_cnt_t;

  localparam int NUM_COLS_W = 6;
  localparam int REFRESH_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REFRESH = 1'd1;

  localparam logic [1:0] KIND_RAW = 2'd0;
  localparam logic [1:0] KIND_SMALL = 2'd1;
  localparam logic [1:0] KIND_MEDIUM = 2'd2;

  localparam logic [31:0] SMALL_LIMIT = 32'd8191;
  localparam logic [31:0] MEDIUM_LIMIT = 32'd2097151;
  localparam logic [15:0] REFRESH_MAX = 16'hFFFF;

  localparam logic [7:0] RAW_TOP_MASK = 8'b0111_1111;
  localparam logic [7:0] DELTA_LEAD = 8'b1110_0000;
  localparam logic [7:0] DOWN_MASK = 8'b1011_1111;
  localparam logic [7:0] SMALL_MASK = 8'b1101_1111;

endpackage

// ----- sv/multi_column_delta_byte_encoder_core.sv -----
// Multi-column delta byte encoder, top level.
// Uses mcdbe_pkg for sizes, code kinds and byte masks.
//
// Usage:
//   Samples enter on sample/sample_valid/sample_stall, one 32-bit value per
//   transaction, in column order; num_cols columns make one row. Encoded
//   bytes leave on out_byte/byte_valid/byte_stall with last_of_sample,
//   end_of_row and code_kind alongside every byte.
//   A raw sample gives four bytes, a two-byte delta two, a three-byte
//   delta three. Bytes go out one per cycle while byte_stall is low, and
//   the byte serializer sets the throughput. A sample passes through
//   the input register and then the encoder register before its first
//   byte leaves.
//   The input register takes the next sample while the current one is
//   still being shifted out, so the output stays busy back to back.
//   When the receiver stalls, the current byte holds, and sample_stall
//   rises once the input register is also full.
//   Reset clears the column position, the row counters and the pipeline,
//   and sets num_cols to 1 and refresh_interval to 0. Configuration is
//   written through cfg_write/cfg_index/cfg_data while the block is idle.
module multi_column_delta_byte_encoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mcdbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mcdbe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [31:0]                         sample,
  output logic                                byte_valid,
  input  logic                                byte_stall,
  output logic [7:0]                          out_byte,
  output logic                                last_of_sample,
  output logic                                end_of_row,
  output logic [1:0]                          code_kind
);

  // Configuration registers.
  logic [mcdbe_pkg::NUM_COLS_W-1:0] num_cols;
  logic [mcdbe_pkg::REFRESH_W-1:0]  refresh_interval;

  // Encoder state.
  logic [31:0]          last_values [mcdbe_pkg::MAX_COLUMNS];
  mcdbe_pkg::col_idx_t  column_index;
  logic                 row_is_raw;
  logic                 have_origin;
  logic [15:0]          rows_since_refresh;

  // Input register.
  logic        in_full;
  logic [31:0] in_sample;

  // Byte serializer: bytes are left aligned and shifted out from the top.
  logic        pack_valid;
  logic [31:0] pack_data;
  logic [1:0]  pack_left;
  logic        pack_eor;
  logic [1:0]  pack_kind;

  logic                byte_take;
  logic                load;
  mcdbe_pkg::col_cnt_t cols;
  mcdbe_pkg::col_cnt_t col_sel;
  mcdbe_pkg::col_idx_t col;
  logic                eor;
  logic                refresh;
  logic                row_start;
  logic                start_raw;
  logic                cur_raw;
  logic [31:0]         prev;
  logic                up;
  logic [31:0]         mag;
  logic [7:0]          lead_byte;
  logic [31:0]         enc_data;
  logic [1:0]          enc_left;
  logic [1:0]          enc_kind;

  assign byte_take = pack_valid && !byte_stall;
  assign load = in_full && (!pack_valid || (byte_take && (pack_left == 2'd0)));
  assign sample_stall = in_full && !load;

  assign byte_valid = pack_valid;
  assign out_byte = pack_data[31:24];
  assign last_of_sample = (pack_left == 2'd0);
  assign end_of_row = pack_eor;
  assign code_kind = pack_kind;

  // Column bookkeeping. A column count of zero acts as one column.
  always_comb begin
    if (num_cols == '0) begin
      cols = mcdbe_pkg::col_cnt_t'(1);
    end else if (int'(num_cols) > mcdbe_pkg::MAX_COLUMNS) begin
      cols = mcdbe_pkg::col_cnt_t'(mcdbe_pkg::MAX_COLUMNS);
    end else begin
      cols = mcdbe_pkg::col_cnt_t'(num_cols);
    end
    // If the count shrank mid-row, the current sample closes the row.
    if (mcdbe_pkg::col_cnt_t'(column_index) >= cols) begin
      col_sel = cols - mcdbe_pkg::col_cnt_t'(1);
    end else begin
      col_sel = mcdbe_pkg::col_cnt_t'(column_index);
    end
    col = col_sel[mcdbe_pkg::COL_W-1:0];
    eor = (col_sel + mcdbe_pkg::col_cnt_t'(1)) >= cols;
  end

  // Raw or delta decision for the row, taken on column zero.
  always_comb begin
    row_start = (column_index == '0);
    refresh = (refresh_interval != '0) && (rows_since_refresh >= refresh_interval);
    start_raw = !have_origin || refresh;
    cur_raw = row_start ? start_raw : row_is_raw;
  end

  always_comb begin
    prev = last_values[col];
    up = (in_sample >= prev);
    mag = up ? (in_sample - prev) : (prev - in_sample);
    lead_byte = mcdbe_pkg::DELTA_LEAD;
    enc_data = {in_sample[31:24] & mcdbe_pkg::RAW_TOP_MASK, in_sample[23:0]};
    enc_left = 2'd3;
    enc_kind = mcdbe_pkg::KIND_RAW;
    if (!cur_raw && (mag <= mcdbe_pkg::SMALL_LIMIT)) begin
      lead_byte = (mcdbe_pkg::DELTA_LEAD | {3'b000, mag[12:8]}) & mcdbe_pkg::SMALL_MASK;
      if (!up) begin
        lead_byte = lead_byte & mcdbe_pkg::DOWN_MASK;
      end
      enc_data = {lead_byte, mag[7:0], 16'h0000};
      enc_left = 2'd1;
      enc_kind = mcdbe_pkg::KIND_SMALL;
    end else if (!cur_raw && (mag <= mcdbe_pkg::MEDIUM_LIMIT)) begin
      lead_byte = mcdbe_pkg::DELTA_LEAD | {3'b000, mag[20:16]};
      if (!up) begin
        lead_byte = lead_byte & mcdbe_pkg::DOWN_MASK;
      end
      enc_data = {lead_byte, mag[15:0], 8'h00};
      enc_left = 2'd2;
      enc_kind = mcdbe_pkg::KIND_MEDIUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= mcdbe_pkg::NUM_COLS_W'(1);
      refresh_interval <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        mcdbe_pkg::CFG_NUM_COLS: num_cols <= cfg_data[mcdbe_pkg::NUM_COLS_W-1:0];
        mcdbe_pkg::CFG_REFRESH:  refresh_interval <= cfg_data[mcdbe_pkg::REFRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_is_raw <= 1'b0;
      have_origin <= 1'b0;
      rows_since_refresh <= '0;
    end else if (load) begin
      column_index <= eor ? '0 : col + mcdbe_pkg::col_idx_t'(1);
      if (row_start) begin
        row_is_raw <= start_raw;
        if (start_raw) begin
          rows_since_refresh <= '0;
          have_origin <= 1'b1;
        end else if (rows_since_refresh != mcdbe_pkg::REFRESH_MAX) begin
          rows_since_refresh <= rows_since_refresh + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_values[col] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_valid <= 1'b0;
      pack_left <= 2'd0;
    end else if (load) begin
      pack_valid <= 1'b1;
      pack_left <= enc_left;
    end else if (byte_take) begin
      if (pack_left == 2'd0) begin
        pack_valid <= 1'b0;
      end else begin
        pack_left <= pack_left - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pack_data <= enc_data;
      pack_eor <= eor;
      pack_kind <= enc_kind;
    end else if (byte_take) begin
      pack_data <= {pack_data[23:0], 8'h00};
    end
  end

  // A sample's bytes go out without a different sample cutting in.
  assert property (@(posedge clk) disable iff (rst)
    byte_take && !last_of_sample |=> byte_valid && $stable(code_kind) && $stable(end_of_row))
    else $error("sample interrupted before its last byte");

  // The first byte carries the marker bit: clear for raw, set for a delta.
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && (code_kind == mcdbe_pkg::KIND_RAW) && (pack_left == 2'd3) |-> !out_byte[7])
    else $error("raw lead byte has marker bit set");

  assert property (@(posedge clk) disable iff (rst)
    byte_valid && (((code_kind == mcdbe_pkg::KIND_SMALL) && (pack_left == 2'd1)) ||
                   ((code_kind == mcdbe_pkg::KIND_MEDIUM) && (pack_left == 2'd2)))
    |-> out_byte[7])
    else $error("delta lead byte has marker bit clear");

  // A sample that ends a row sends the next one to column zero.
  assert property (@(posedge clk) disable iff (rst)
    load && eor |=> column_index == '0)
    else $error("column index not wrapped at end of row");

  // An empty input register never holds off the sender.
  assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !sample_stall)
    else $error("stall raised with empty input register");

endmodule
